@@ rtl/svn_pkg.sv @@
// Shared types and constants of the softmax vector normalizer.
// Holds the queue entry type and the base-2 exponent fraction table builder.
// No dependencies.
package svn_pkg;

    // Field widths fixed by the data formats.
    localparam int LOGIT_W = 16;
    localparam int EXP_W   = 17;
    localparam int SUM_W   = 23;
    localparam int PROB_W  = 16;
    localparam int TBL_N   = 256;

    // log2(e) in Q1.16 and 2^(-1/256) in Q1.31.
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] STEP_Q31  = 64'd2141676973;

    // Exponents at or above this shift underflow to zero.
    localparam logic [8:0] EXP_SHIFT_MAX = 9'd17;

    localparam logic [PROB_W-1:0] PROB_SAT = '1;

    // One beat as it travels from the front to the back.
    typedef struct packed {
        logic [LOGIT_W-1:0] logit;
        logic               last;
        logic               keep;
    } svn_item_t;

    typedef logic [EXP_W-1:0] exp_tbl_t [TBL_N];

    // Table of 2^(-f/256) in Q1.16, built by repeated Q1.31 steps.
    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t    tbl;
        logic [63:0] v;
        logic [63:0] r;
        v = 64'd1 << 31;
        for (int f = 0; f < TBL_N; f++)
        begin
            r      = (v + (64'd1 << 14)) >> 15;
            tbl[f] = r[EXP_W-1:0];
            v      = (v * STEP_Q31 + (64'd1 << 30)) >> 31;
        end
        return tbl;
    endfunction

endpackage

@@ rtl/svn_queue.sv @@
// Two-entry queue between the front and the back of the normalizer.
// Depends on svn_pkg for the entry type.
module svn_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  svn_pkg::svn_item_t wr_item,
    input  logic              pop,
    output svn_pkg::svn_item_t rd_item,
    output logic              empty,
    output logic              full
);
    import svn_pkg::*;

    svn_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign empty   = (fill_reg == 2'd0);
    assign full    = (fill_reg == 2'd2);
    assign rd_item = entry_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/svn_front.sv @@
// Front of the normalizer: accepts beats and marks each as kept or dropped.
// Depends on svn_pkg for the item type.
module svn_front #(
    parameter int MAX_LEN = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [svn_pkg::LOGIT_W-1:0] logit,
    input  logic                         last_in,
    input  logic                         q_full,
    output logic                         busy,
    output logic                         push,
    output svn_pkg::svn_item_t          item
);
    import svn_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_LEN);

    logic [CW-1:0] count_reg;
    logic          keep;

    assign busy = q_full;
    assign push = start && !q_full;
    assign keep = (count_reg < CAP);

    assign item.logit = logit;
    assign item.last  = last_in;
    assign item.keep  = keep;

    // Count of kept elements in the current vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            if (last_in)
            begin
                count_reg <= '0;
            end
            else if (keep)
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

endmodule

@@ rtl/svn_back.sv @@
// Back of the normalizer: stores elements, runs the exponent and divide passes.
// Depends on svn_pkg for the item type, table and constants.
module svn_back #(
    parameter int MAX_LEN = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  svn_pkg::svn_item_t         q_item,
    output logic                        pop,
    output logic                        strobe,
    output logic [svn_pkg::PROB_W-1:0] probability,
    output logic                        last_out,
    output logic                        overflow
);
    import svn_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam exp_tbl_t EXP_TBL = build_exp_tbl();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_RD,
        ST_EXP_MUL,
        ST_EXP_WR,
        ST_DIV_RD,
        ST_DIV_LD,
        ST_DIV_ITER,
        ST_DIV_OUT
    } state_t;

    state_t              state_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       idx_reg;
    logic [LOGIT_W-1:0]  max_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                dropped_reg;
    logic [EXP_W-1:0]    y_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [PROB_W-1:0]   quot_reg;
    logic [3:0]          bit_reg;
    logic                strobe_reg;
    logic [PROB_W-1:0]   prob_reg;
    logic                last_reg;
    logic                ovf_reg;

    logic [LOGIT_W-1:0]  logit_mem [MAX_LEN];
    logic [EXP_W-1:0]    exp_mem   [MAX_LEN];
    logic [LOGIT_W-1:0]  logit_rd_reg;
    logic [EXP_W-1:0]    exp_rd_reg;

    logic [LOGIT_W-1:0]  u;
    logic [32:0]         prod;
    logic [8:0]          shift_n;
    logic [EXP_W-1:0]    exp_val;
    logic [SUM_W:0]      rem_dbl;
    logic                rem_ge;
    logic                is_last_idx;
    logic                exp_wr_en;
    logic                logit_wr_en;

    assign strobe      = strobe_reg;
    assign probability = prob_reg;
    assign last_out    = last_reg;
    assign overflow    = ovf_reg;

    assign pop         = (state_reg == ST_IDLE) && !q_empty;
    assign logit_wr_en = pop && q_item.keep && (count_reg < CW'(MAX_LEN));
    assign exp_wr_en   = (state_reg == ST_EXP_WR);
    assign is_last_idx = (idx_reg + CW'(1) == count_reg);

    // Exponent datapath: distance from the maximum times log2(e).
    assign u       = max_reg - logit_rd_reg;
    assign prod    = {17'd0, u} * {16'd0, LOG2E_Q16};
    assign shift_n = y_reg[EXP_W-1:8];
    assign exp_val = (shift_n >= EXP_SHIFT_MAX) ? '0 :
                     (EXP_TBL[y_reg[7:0]] >> shift_n[4:0]);

    // One restoring division step.
    assign rem_dbl = {rem_reg, 1'b0};
    assign rem_ge  = (rem_dbl >= {1'b0, sum_reg});

    // Logit store.
    always_ff @(posedge clk)
    begin
        if (logit_wr_en)
        begin
            logit_mem[count_reg[AW-1:0]] <= q_item.logit;
        end
        logit_rd_reg <= logit_mem[idx_reg[AW-1:0]];
    end

    // Exponent store.
    always_ff @(posedge clk)
    begin
        if (exp_wr_en)
        begin
            exp_mem[idx_reg[AW-1:0]] <= exp_val;
        end
        exp_rd_reg <= exp_mem[idx_reg[AW-1:0]];
    end

    // Sequencer and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            max_reg     <= {1'b1, {(LOGIT_W-1){1'b0}}};
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
            y_reg       <= '0;
            rem_reg     <= '0;
            quot_reg    <= '0;
            bit_reg     <= '0;
            strobe_reg  <= 1'b0;
            prob_reg    <= '0;
            last_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (logit_wr_en)
                        begin
                            count_reg <= count_reg + CW'(1);
                            if ($signed(q_item.logit) > $signed(max_reg))
                            begin
                                max_reg <= q_item.logit;
                            end
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (q_item.last)
                        begin
                            idx_reg   <= '0;
                            sum_reg   <= '0;
                            if (logit_wr_en || count_reg != '0)
                            begin
                                state_reg <= ST_EXP_RD;
                            end
                            else
                            begin
                                max_reg     <= {1'b1, {(LOGIT_W-1){1'b0}}};
                                dropped_reg <= 1'b0;
                            end
                        end
                    end
                end
                ST_EXP_RD:
                begin
                    state_reg <= ST_EXP_MUL;
                end
                ST_EXP_MUL:
                begin
                    y_reg     <= prod[32:16];
                    state_reg <= ST_EXP_WR;
                end
                ST_EXP_WR:
                begin
                    sum_reg <= sum_reg + SUM_W'(exp_val);
                    if (is_last_idx)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_DIV_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_EXP_RD;
                    end
                end
                ST_DIV_RD:
                begin
                    state_reg <= ST_DIV_LD;
                end
                ST_DIV_LD:
                begin
                    // Zero sum gives zero; a share of one or more saturates.
                    if (sum_reg == '0)
                    begin
                        quot_reg  <= '0;
                        state_reg <= ST_DIV_OUT;
                    end
                    else if (SUM_W'(exp_rd_reg) >= sum_reg)
                    begin
                        quot_reg  <= PROB_SAT;
                        state_reg <= ST_DIV_OUT;
                    end
                    else
                    begin
                        rem_reg   <= SUM_W'(exp_rd_reg);
                        quot_reg  <= '0;
                        bit_reg   <= '0;
                        state_reg <= ST_DIV_ITER;
                    end
                end
                ST_DIV_ITER:
                begin
                    rem_reg  <= rem_ge ? SUM_W'(rem_dbl - {1'b0, sum_reg})
                                       : rem_dbl[SUM_W-1:0];
                    quot_reg <= {quot_reg[PROB_W-2:0], rem_ge};
                    bit_reg  <= bit_reg + 4'd1;
                    if (bit_reg == 4'd15)
                    begin
                        state_reg <= ST_DIV_OUT;
                    end
                end
                ST_DIV_OUT:
                begin
                    strobe_reg <= 1'b1;
                    prob_reg   <= quot_reg;
                    last_reg   <= is_last_idx;
                    ovf_reg    <= dropped_reg;
                    if (is_last_idx)
                    begin
                        count_reg   <= '0;
                        idx_reg     <= '0;
                        max_reg     <= {1'b1, {(LOGIT_W-1){1'b0}}};
                        sum_reg     <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_DIV_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/softmax_vector_normalizer.sv @@
// Softmax normalizer: beats load one per cycle via a two-entry queue while the back
// is idle; after the last beat, per element, the exponent pass runs read, multiply
// and write, the divide pass read, load, one quotient bit per cycle (saturated: none), output.
// Probabilities leave on strobe in input order; the receiver cannot stall them.
// Reset clears all control state; the element stores need no reset.
// Depends on svn_pkg, svn_front, svn_queue and svn_back.
module softmax_vector_normalizer #(
    parameter int MAX_LEN = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [svn_pkg::LOGIT_W-1:0] logit,
    input  logic                        last_in,
    output logic                        strobe,
    output logic [svn_pkg::PROB_W-1:0]  probability,
    output logic                        last_out,
    output logic                        overflow
);
    import svn_pkg::*;

    svn_item_t wr_item;
    svn_item_t rd_item;
    logic      push;
    logic      pop;
    logic      q_empty;
    logic      q_full;

    // Front classifies beats.
    svn_front #(.MAX_LEN(MAX_LEN)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .logit   (logit),
        .last_in (last_in),
        .q_full  (q_full),
        .busy    (busy),
        .push    (push),
        .item    (wr_item)
    );

    // Queue decouples front and back.
    svn_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .empty   (q_empty),
        .full    (q_full)
    );

    // Back stores and normalizes.
    svn_back #(.MAX_LEN(MAX_LEN)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_item      (rd_item),
        .pop         (pop),
        .strobe      (strobe),
        .probability (probability),
        .last_out    (last_out),
        .overflow    (overflow)
    );

endmodule
